FILE: hw/rtl/bsbcl_pkg.sv
// Package with shared types and constants for the button-set blink-code LED.
package bsbcl_pkg;

    localparam int unsigned IN_BYTES_W  = 8;
    localparam int unsigned OUT_BYTES_W = 8;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam int unsigned DEB_W   = 10;
    localparam int unsigned LONG_W  = 16;
    localparam int unsigned PAUSE_W = 8;
    localparam int unsigned CNT_W   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_MS   = 3'd0,
        CFG_LONG_PRESS_MS = 3'd1,
        CFG_PAUSE_SECONDS = 3'd2,
        CFG_COUNT_MIN     = 3'd3,
        CFG_COUNT_MAX     = 3'd4
    } t_cfg_idx;

    localparam logic [DEB_W-1:0]   RST_DEBOUNCE_MS   = 10'd50;
    localparam logic [LONG_W-1:0]  RST_LONG_PRESS_MS = 16'd3000;
    localparam logic [PAUSE_W-1:0] RST_PAUSE_SECONDS = 8'd5;
    localparam logic [CNT_W-1:0]   RST_COUNT_MIN     = 4'd4;
    localparam logic [CNT_W-1:0]   RST_COUNT_MAX     = 4'd7;
    localparam logic [CNT_W-1:0]   RST_COUNT         = 4'd4;

    localparam logic [CNT_W-1:0]   FLASHES_SAT = 4'hF;
    localparam logic [PAUSE_W-1:0] PAUSE_SAT   = 8'hFF;

endpackage

FILE: hw/rtl/button_set_blink_code_led.sv
// Top level of the button-set blink-code LED: press timing, count update and flash sequencer.
//
//  Channel      | Direction | Beat contents (lowest bit first)
//  -------------+-----------+-------------------------------------------------
//  s_axis       | in        | tdata: button_down, second_tick, zero fill
//  m_axis       | out       | tdata: led_on, flash_count[3:0], store_request,
//               |           |        zero fill
//  cfg          | in        | i_cfg_we, i_cfg_idx, i_cfg_wdata, no read-back
//
// One beat is accepted in every cycle while the output side keeps up. An accepted beat
// sits in the input register and its result is loaded into the result register once that
// is free; the state update is a single pass of logic between the two registers.
// The reset is synchronous and active low; it clears both valids and all running state.
// When the result is not taken the output register holds, the input register fills,
// and only then is s_axis_tready dropped.
module button_set_blink_code_led #(
    parameter int unsigned PRESS_TIMER_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // bit 0 button_down, bit 1 second_tick, bits 7:2 zero
    input  logic [bsbcl_pkg::IN_BYTES_W-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // bit 0 led_on, bits 4:1 flash_count, bit 5 store_request, bits 7:6 zero
    output logic [bsbcl_pkg::OUT_BYTES_W-1:0]   m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [bsbcl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bsbcl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import bsbcl_pkg::*;

    // Width used to compare the press timer against the millisecond limits.
    localparam int unsigned CMP_W = (PRESS_TIMER_BITS > LONG_W) ? PRESS_TIMER_BITS : LONG_W;
    localparam logic [PRESS_TIMER_BITS-1:0] TIMER_MAX = {PRESS_TIMER_BITS{1'b1}};

    // Configuration registers.
    logic [DEB_W-1:0]   r_debounce_ms;
    logic [LONG_W-1:0]  r_long_press_ms;
    logic [PAUSE_W-1:0] r_pause_seconds;
    logic [CNT_W-1:0]   r_count_min;
    logic [CNT_W-1:0]   r_count_max;

    // Pipeline registers.
    logic       r_in_valid;
    logic       r_in_down;
    logic       r_in_tick;
    logic       r_out_valid;
    logic       r_out_led;
    logic [CNT_W-1:0] r_out_count;
    logic       r_out_store;

    // Running state.
    logic                        r_press_active, n_press_active;
    logic [PRESS_TIMER_BITS-1:0] r_press_timer,  n_press_timer;
    logic                        r_long_done,    n_long_done;
    logic [CNT_W-1:0]            r_count,        n_count;
    logic [CNT_W-1:0]            r_flashes_done, n_flashes_done;
    logic                        r_pausing,      n_pausing;
    logic [PAUSE_W-1:0]          r_pause_elapsed, n_pause_elapsed;
    logic                        r_led_phase,    n_led_phase;
    logic                        n_store;

    logic out_free;
    logic proc_fire;
    logic in_accept;

    logic [PRESS_TIMER_BITS-1:0] timer_inc;
    logic [CMP_W-1:0]            timer_cmp;
    logic [CMP_W-1:0]            long_cmp;
    logic [CMP_W-1:0]            deb_cmp;
    logic [CNT_W:0]              count_next;
    logic [PAUSE_W-1:0]          pause_inc;
    logic [CNT_W-1:0]            flashes_inc;

    // The result register frees up when it is empty or being drained; the
    // input register can take a beat when it is empty or moving on.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc_fire     = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_store, r_out_count, r_out_led};

    // Register writes: an index outside the list is simply ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= RST_DEBOUNCE_MS;
            r_long_press_ms <= RST_LONG_PRESS_MS;
            r_pause_seconds <= RST_PAUSE_SECONDS;
            r_count_min     <= RST_COUNT_MIN;
            r_count_max     <= RST_COUNT_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg_wdata[DEB_W-1:0];
                CFG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_wdata[LONG_W-1:0];
                CFG_PAUSE_SECONDS: r_pause_seconds <= i_cfg_wdata[PAUSE_W-1:0];
                CFG_COUNT_MIN:     r_count_min     <= i_cfg_wdata[CNT_W-1:0];
                CFG_COUNT_MAX:     r_count_max     <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_down <= s_axis_tdata[0];
            r_in_tick <= s_axis_tdata[1];
        end
    end

    // Button handling first, then the second tick, both in one pass.
    always_comb begin
        n_press_active  = r_press_active;
        n_press_timer   = r_press_timer;
        n_long_done     = r_long_done;
        n_count         = r_count;
        n_flashes_done  = r_flashes_done;
        n_pausing       = r_pausing;
        n_pause_elapsed = r_pause_elapsed;
        n_led_phase     = r_led_phase;
        n_store         = 1'b0;

        // The press timer saturates rather than wrapping.
        timer_inc = (r_press_active && (r_press_timer != TIMER_MAX)) ?
                    r_press_timer + 1'b1 : r_press_timer;
        timer_cmp = CMP_W'(timer_inc);
        long_cmp  = CMP_W'(r_long_press_ms);
        deb_cmp   = CMP_W'(r_debounce_ms);
        n_press_timer = timer_inc;

        count_next = {1'b0, r_count} + 1'b1;

        if (r_in_down) begin
            if (!r_press_active) begin
                n_press_active = 1'b1;
                n_press_timer  = '0;
                n_long_done    = 1'b0;
            end else if (!r_long_done && (timer_cmp >= long_cmp)) begin
                // Long hold: fall back to the minimum count once per press.
                n_count     = r_count_min;
                n_long_done = 1'b1;
                n_store     = 1'b1;
            end
        end else if (r_press_active) begin
            if ((timer_cmp > deb_cmp) && (timer_cmp < long_cmp) && !r_long_done) begin
                n_count = (count_next > {1'b0, r_count_max}) ?
                          r_count_min : count_next[CNT_W-1:0];
                n_store = 1'b1;
            end
            n_press_active = 1'b0;
        end

        pause_inc   = (r_pause_elapsed != PAUSE_SAT) ? r_pause_elapsed + 1'b1 : r_pause_elapsed;
        flashes_inc = (r_flashes_done != FLASHES_SAT) ? r_flashes_done + 1'b1 : r_flashes_done;

        if (r_in_tick) begin
            if (r_pausing) begin
                if (pause_inc >= r_pause_seconds) begin
                    n_pausing       = 1'b0;
                    n_pause_elapsed = '0;
                    n_flashes_done  = '0;
                    n_led_phase     = 1'b0;
                end else begin
                    n_pause_elapsed = pause_inc;
                end
            end else if (!r_led_phase) begin
                n_led_phase = 1'b1;
            end else begin
                // End of a lit tick; the burst ends against the updated count.
                n_led_phase    = 1'b0;
                n_flashes_done = flashes_inc;
                if (flashes_inc >= n_count) begin
                    n_pausing       = 1'b1;
                    n_pause_elapsed = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_active  <= 1'b0;
            r_press_timer   <= '0;
            r_long_done     <= 1'b0;
            r_count         <= RST_COUNT;
            r_flashes_done  <= '0;
            r_pausing       <= 1'b0;
            r_pause_elapsed <= '0;
            r_led_phase     <= 1'b0;
        end else if (proc_fire) begin
            r_press_active  <= n_press_active;
            r_press_timer   <= n_press_timer;
            r_long_done     <= n_long_done;
            r_count         <= n_count;
            r_flashes_done  <= n_flashes_done;
            r_pausing       <= n_pausing;
            r_pause_elapsed <= n_pause_elapsed;
            r_led_phase     <= n_led_phase;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out_led   <= n_led_phase;
            r_out_count <= n_count;
            r_out_store <= n_store;
        end
    end

`ifndef SYNTHESIS
    // The LED is always dark while the pause runs.
    a_dark_in_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pausing |-> !r_led_phase)
        else $error("LED lit during pause");

    // A beat held in the input register waits unchanged for the result slot.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_down) && $stable(r_in_tick)))
        else $error("input register lost a stalled beat");

    // A processed beat always leaves a result behind, carrying the new count.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire |=> (r_out_valid && (r_out_count == r_count)))
        else $error("result does not follow processed beat");
`endif

endmodule

FILE: tb/button_set_blink_code_led_tb.sv
// Self-checking testbench for the button-set blink-code LED with its own predictor of every result beat.
`timescale 1ns / 1ps

module button_set_blink_code_led_tb;

    import bsbcl_pkg::*;

    // Width of the press timer; it matches the default of the block.
    localparam int unsigned TIMER_W     = 16;
    localparam int          CYCLE_LIMIT = 2_000_000;
    // An index past the end of the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    // One button sample as it travels on the input stream, down in bit 0.
    typedef struct packed {
        logic tick;
        logic down;
    } sample_t;

    // The fields of one result beat.
    typedef struct packed {
        logic             led;
        logic [CNT_W-1:0] count;
        logic             store;
    } report_t;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_BYTES_W-1:0] s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    button_set_blink_code_led #(
        .PRESS_TIMER_BITS(TIMER_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor state. The register copies follow every write made by the
    // stimulus; the rest mirrors the press timer and the flash sequencer.
    // ------------------------------------------------------------------
    logic [DEB_W-1:0]   cfg_debounce = RST_DEBOUNCE_MS;
    logic [LONG_W-1:0]  cfg_long     = RST_LONG_PRESS_MS;
    logic [PAUSE_W-1:0] cfg_pause    = RST_PAUSE_SECONDS;
    logic [CNT_W-1:0]   cfg_min      = RST_COUNT_MIN;
    logic [CNT_W-1:0]   cfg_max      = RST_COUNT_MAX;

    logic               held          = 1'b0;
    logic [TIMER_W-1:0] hold_ms       = '0;
    logic               long_fired    = 1'b0;
    logic [CNT_W-1:0]   flash_cnt     = RST_COUNT;
    logic [CNT_W-1:0]   flashes_shown = '0;
    logic               in_pause      = 1'b0;
    logic [PAUSE_W-1:0] pause_ticks   = '0;
    logic               lit           = 1'b0;

    sample_t pending_samples[$];
    report_t expected_reports[$];

    sample_t offered;
    report_t want;
    bit      beat_taken      = 1'b0;
    bit      calm            = 1'b0;
    int      send_gap        = 0;
    int      stall_left      = 0;
    int      hold_off_cycles = 0;
    int      queued_count    = 0;
    int      mismatch_cnt    = 0;
    int      cycle_count     = 0;

    // Advances the predicted state by one millisecond sample and returns the
    // beat the block should produce for it. The button is handled before the
    // second tick, exactly as the block orders them.
    function automatic report_t advance_blink_code(sample_t s);
        report_t          r;
        logic [CNT_W:0]   bumped;
        r.store = 1'b0;
        // The timer runs on every sample after the first of a press, the
        // release sample included, and sticks at its top value.
        if (held && hold_ms != '1) begin
            hold_ms++;
        end
        if (s.down) begin
            if (!held) begin
                held       = 1'b1;
                hold_ms    = '0;
                long_fired = 1'b0;
            end else if (!long_fired && hold_ms >= cfg_long) begin
                flash_cnt  = cfg_min;
                long_fired = 1'b1;
                r.store    = 1'b1;
            end
        end else if (held) begin
            if (hold_ms > cfg_debounce && hold_ms < cfg_long && !long_fired) begin
                // The raise is one bit wider so that 15 + 1 still wraps.
                bumped    = {1'b0, flash_cnt} + 1'b1;
                flash_cnt = (bumped > {1'b0, cfg_max}) ? cfg_min : bumped[CNT_W-1:0];
                r.store   = 1'b1;
            end
            held = 1'b0;
        end
        if (s.tick) begin
            if (in_pause) begin
                if (pause_ticks != PAUSE_SAT) begin
                    pause_ticks++;
                end
                if (pause_ticks >= cfg_pause) begin
                    in_pause      = 1'b0;
                    pause_ticks   = '0;
                    flashes_shown = '0;
                    lit           = 1'b0;
                end
            end else if (!lit) begin
                lit = 1'b1;
            end else begin
                lit = 1'b0;
                if (flashes_shown != FLASHES_SAT) begin
                    flashes_shown++;
                end
                // Compared against the live count, so a count lowered during
                // a burst cuts the burst short at the next dark tick.
                if (flashes_shown >= flash_cnt) begin
                    in_pause    = 1'b1;
                    pause_ticks = '0;
                end
            end
        end
        r.led   = lit;
        r.count = flash_cnt;
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Values change on the falling edge; a beat is taken at the
    // rising edge where tvalid and tready are both high. The prediction is
    // made at that edge, from the sample that was on the bus.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_reports.push_back(advance_blink_code(offered));
            beat_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || beat_taken) begin
            if (beat_taken) begin
                beat_taken = 1'b0;
                send_gap   = pick_gap();
            end
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                offered = pending_samples.pop_front();
                s_axis_tdata  <= IN_BYTES_W'(offered);
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. Random stalls, plus a long hold-off on request that lets
    // the block fill up and push back on its input.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Every result beat is checked field by field against the oldest
    // prediction still waiting.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, got %h",
                         $time, m_axis_tdata);
                mismatch_cnt++;
            end else begin
                want = expected_reports.pop_front();
                if (m_axis_tdata[0] !== want.led) begin
                    $display("%0t: led_on expected %0d, got %0d",
                             $time, want.led, m_axis_tdata[0]);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[4:1] !== want.count) begin
                    $display("%0t: flash_count expected %0d, got %0d",
                             $time, want.count, m_axis_tdata[4:1]);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[5] !== want.store) begin
                    $display("%0t: store_request expected %0d, got %0d",
                             $time, want.store, m_axis_tdata[5]);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Guard against a hang: the slowest correct run is far below this.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("button_set_blink_code_led: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Register writes happen only with the block idle, so the predictor's
    // copy can be updated straight away.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_DEBOUNCE_MS:   cfg_debounce = value[DEB_W-1:0];
            CFG_LONG_PRESS_MS: cfg_long     = value[LONG_W-1:0];
            CFG_PAUSE_SECONDS: cfg_pause    = value[PAUSE_W-1:0];
            CFG_COUNT_MIN:     cfg_min      = value[CNT_W-1:0];
            CFG_COUNT_MAX:     cfg_max      = value[CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_sample(input bit down, input bit tick);
        sample_t s;
        s.down = down;
        s.tick = tick;
        pending_samples.push_back(s);
        queued_count++;
    endtask

    // A press of held_len pressed samples followed by idle_len released ones.
    task automatic queue_press(input int held_len, input int idle_len, input int tick_pct);
        for (int k = 0; k < held_len; k++) begin
            push_sample(1'b1, roll(tick_pct));
        end
        for (int k = 0; k < idle_len; k++) begin
            push_sample(1'b0, roll(tick_pct));
        end
    endtask

    // Waits until every sample has been sent and every result checked, then
    // idles on as a margin.
    task automatic drain();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // One random phase: random settings, then mostly well-formed presses of
    // chosen lengths around the thresholds, with some noise mixed in.
    task automatic run_random_phase(input int n_items, input bit squeeze);
        int deb;
        int lng;
        int lo;
        int hi;
        int tmp;
        int pct;
        int start;
        int held_len;
        int pick;
        deb = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        lng = ($urandom_range(0, 9) == 0) ? 0 : deb + $urandom_range(2, 40);
        lo  = $urandom_range(0, 15);
        hi  = $urandom_range(0, 15);
        // Keep most settings sensible but leave room for a minimum above the maximum.
        if (lo > hi && roll(70)) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        set_reg(CFG_DEBOUNCE_MS, CFG_DATA_W'(deb));
        set_reg(CFG_LONG_PRESS_MS, CFG_DATA_W'(lng));
        set_reg(CFG_PAUSE_SECONDS, CFG_DATA_W'($urandom_range(0, 4)));
        set_reg(CFG_COUNT_MIN, CFG_DATA_W'(lo));
        set_reg(CFG_COUNT_MAX, CFG_DATA_W'(hi));
        pct  = $urandom_range(10, 60);
        calm = ($urandom_range(0, 3) == 0);
        if (squeeze) begin
            calm            = 1'b0;
            hold_off_cycles = 300;
        end
        start = queued_count;
        while (queued_count - start < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick == 7) begin
                // Noise: the button level changes at random, bounces included.
                repeat ($urandom_range(1, 8)) push_sample(1'($urandom_range(0, 1)), roll(pct));
            end else begin
                case (pick)
                    0, 1: begin
                        held_len = $urandom_range(1, (deb > 1) ? deb : 1);
                    end
                    5: begin
                        held_len = lng + $urandom_range(1, 30);
                    end
                    6: begin
                        case ($urandom_range(0, 4))
                            0:       held_len = deb;
                            1:       held_len = deb + 1;
                            2:       held_len = lng - 1;
                            3:       held_len = lng;
                            default: held_len = lng + 1;
                        endcase
                    end
                    default: begin
                        held_len = (lng > deb + 1) ? $urandom_range(deb + 1, lng - 1) : deb + 1;
                    end
                endcase
                if (held_len < 1) begin
                    held_len = 1;
                end
                queue_press(held_len, $urandom_range(1, 12), pct);
            end
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: ticks alone first, then presses on either side of
        // the 50 ms debounce, and enough short presses to wrap the count from
        // the maximum of 7 back to 4.
        for (int k = 0; k < 12; k++) begin
            push_sample(1'b0, k % 2 == 0);
        end
        queue_press(50, 5, 20);
        queue_press(51, 5, 20);
        queue_press(60, 3, 20);
        queue_press(60, 3, 20);
        queue_press(60, 3, 20);
        drain();

        // Zero settings: no short press is possible, the long action fires
        // on the second sample, a zero count still gives one flash, and the
        // pause lasts a single tick. A write to a spare index must be ignored.
        set_reg(CFG_DEBOUNCE_MS, 16'd0);
        set_reg(CFG_LONG_PRESS_MS, 16'd0);
        set_reg(CFG_PAUSE_SECONDS, 16'd0);
        set_reg(CFG_COUNT_MIN, 16'd0);
        set_reg(CFG_COUNT_MAX, 16'd15);
        set_reg(CFG_IDX_SPARE, 16'hFFFF);
        push_sample(1'b1, 1'b0);
        push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b0, 1'b1);
        push_sample(1'b0, 1'b1);
        push_sample(1'b0, 1'b1);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b1);
        push_sample(1'b1, 1'b1);
        push_sample(1'b0, 1'b0);
        drain();

        // Minimum above maximum: a short press that raises the count past the maximum lands on the minimum, and
        // a press that leaves the count unchanged still asks for a store.
        set_reg(CFG_DEBOUNCE_MS, 16'd1);
        set_reg(CFG_LONG_PRESS_MS, 16'd4);
        set_reg(CFG_PAUSE_SECONDS, 16'd1);
        set_reg(CFG_COUNT_MIN, 16'd15);
        set_reg(CFG_COUNT_MAX, 16'd1);
        queue_press(2, 1, 50);
        queue_press(3, 1, 50);
        queue_press(2, 1, 50);
        queue_press(1, 1, 50);
        drain();

        // Top settings: the widest debounce and hold, the longest pause, and
        // a count that wraps from 15 back onto itself. A press well inside
        // the widest debounce does nothing; a short debounce then lets the
        // presses wrap the count. No idling here to keep the run short.
        calm = 1'b1;
        set_reg(CFG_DEBOUNCE_MS, 16'd1023);
        set_reg(CFG_LONG_PRESS_MS, 16'd65535);
        set_reg(CFG_PAUSE_SECONDS, 16'd255);
        set_reg(CFG_COUNT_MIN, 16'd15);
        set_reg(CFG_COUNT_MAX, 16'd15);
        queue_press(40, 2, 5);
        drain();
        set_reg(CFG_DEBOUNCE_MS, 16'd2);
        queue_press(5, 2, 5);
        queue_press(5, 2, 5);
        drain();

        // Random phases; the second one holds the receiver off for a long
        // stretch while samples keep coming.
        for (int p = 0; p < 6; p++) begin
            run_random_phase(100, p == 1);
        end

        if (mismatch_cnt == 0) begin
            $display("button_set_blink_code_led: match");
        end else begin
            $display("button_set_blink_code_led: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bsbcl_pkg.sv
hw/rtl/button_set_blink_code_led.sv
tb/button_set_blink_code_led_tb.sv
